### rtl/tieu_pkg.sv
// ----------------------------------------------------------------------------
// tieu_pkg
// Operation codes, compare codes and the item types shared by the execute unit.
// ----------------------------------------------------------------------------
package tieu_pkg;

  localparam int REG_NUM_W = 4;
  localparam int IMM_W     = 32;
  localparam int ADDR_IN_W = 8;
  localparam int RESULT_W  = 32;

  localparam logic [3:0] OP_LDR  = 4'd0;
  localparam logic [3:0] OP_STR  = 4'd1;
  localparam logic [3:0] OP_ADD  = 4'd2;
  localparam logic [3:0] OP_SUB  = 4'd3;
  localparam logic [3:0] OP_MOV  = 4'd4;
  localparam logic [3:0] OP_CMP  = 4'd5;
  localparam logic [3:0] OP_AND  = 4'd6;
  localparam logic [3:0] OP_ORR  = 4'd7;
  localparam logic [3:0] OP_EOR  = 4'd8;
  localparam logic [3:0] OP_MVN  = 4'd9;
  localparam logic [3:0] OP_LSL  = 4'd10;
  localparam logic [3:0] OP_LSR  = 4'd11;
  localparam logic [3:0] OP_HALT = 4'd12;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_GT = 2'd1;
  localparam logic [1:0] CMP_LT = 2'd2;

  // Classified instruction handed from the front to the back.
  typedef struct packed {
    logic [3:0]           op;
    logic                 bad;      // a used register number is out of range
    logic [REG_NUM_W-1:0] rd;       // write target
    logic [REG_NUM_W-1:0] ra;       // port A read: rd for STR and CMP, else rs
    logic [REG_NUM_W-1:0] rb;       // port B read: second operand register
    logic                 use_imm;
    logic [IMM_W-1:0]     imm;
    logic [ADDR_IN_W-1:0] addr;
  } dec_item_t;

  typedef struct packed {
    logic [RESULT_W-1:0] value;
    logic [1:0]          cmp;
    logic                halted;
    logic                bad;
  } result_t;

endpackage

### rtl/teaching_isa_execute_unit.sv
// ----------------------------------------------------------------------------
// teaching_isa_execute_unit
// Runs one decoded instruction per pushed item and returns one result per item.
// After reset the unit clears its register file and data memory in a pass over
// all MEM_WORDS addresses, holding full high meanwhile. It then takes one
// instruction per clock unless full is high: the front checks register numbers
// into a two-entry queue, the back reads the register file and data memory in
// one stage and executes and writes back in the next, forwarding the retiring
// write to the read ports, so dependent instructions also issue back to back.
// Each result waits in a two-entry result queue; a full result queue stalls
// only the back while the front keeps filling its queue.
// ----------------------------------------------------------------------------
module teaching_isa_execute_unit #(
  parameter int NUM_REGS   = 13,
  parameter int MEM_WORDS  = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [3:0]                          operation,
  input  logic [tieu_pkg::REG_NUM_W-1:0]      dest_reg,
  input  logic [tieu_pkg::REG_NUM_W-1:0]      src_reg,
  input  logic                                op2_is_imm,
  input  logic [tieu_pkg::REG_NUM_W-1:0]      op2_reg,
  input  logic [tieu_pkg::IMM_W-1:0]          op2_imm,
  input  logic [tieu_pkg::ADDR_IN_W-1:0]      mem_addr,
  output logic                                empty,
  input  logic                                pop,
  output logic [tieu_pkg::RESULT_W-1:0]       result_value,
  output logic [1:0]                          compare_state,
  output logic                                halted,
  output logic                                bad_register
);

  localparam int DW = $bits(tieu_pkg::dec_item_t);
  localparam int RSW = $bits(tieu_pkg::result_t);

  logic                busy;
  logic                dq_full;
  logic                dq_empty;
  logic                dq_push;
  logic                dq_pop;
  tieu_pkg::dec_item_t dq_in;
  logic [DW-1:0]       dq_out_bits;
  tieu_pkg::dec_item_t dq_out;
  logic                oq_full;
  logic                oq_push;
  tieu_pkg::result_t   oq_in;
  logic [RSW-1:0]      oq_out_bits;
  tieu_pkg::result_t   oq_out;

  tieu_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .push       (push),
    .full       (full),
    .busy       (busy),
    .dq_full    (dq_full),
    .operation  (operation),
    .dest_reg   (dest_reg),
    .src_reg    (src_reg),
    .op2_is_imm (op2_is_imm),
    .op2_reg    (op2_reg),
    .op2_imm    (op2_imm),
    .mem_addr   (mem_addr),
    .dq_push    (dq_push),
    .dq_item    (dq_in)
  );

  tieu_queue #(
    .WIDTH (DW),
    .DEPTH (2)
  ) u_dec_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (dq_push),
    .wr_data (dq_in),
    .rd_en   (dq_pop),
    .rd_data (dq_out_bits),
    .full    (dq_full),
    .empty   (dq_empty)
  );

  assign dq_out = dq_out_bits;

  tieu_back #(
    .NUM_REGS   (NUM_REGS),
    .MEM_WORDS  (MEM_WORDS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .busy     (busy),
    .dq_empty (dq_empty),
    .dq_item  (dq_out),
    .dq_pop   (dq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_in)
  );

  tieu_queue #(
    .WIDTH (RSW),
    .DEPTH (2)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (oq_push),
    .wr_data (oq_in),
    .rd_en   (pop),
    .rd_data (oq_out_bits),
    .full    (oq_full),
    .empty   (empty)
  );

  assign oq_out        = oq_out_bits;
  assign result_value  = oq_out.value;
  assign compare_state = oq_out.cmp;
  assign halted        = oq_out.halted;
  assign bad_register  = oq_out.bad;

  // The back never retires into a full result queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    oq_push |-> !oq_full)
    else $error("result queue overrun");

  // Once a halted result is taken, every later result is halted too.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && halted) |=> (empty || halted))
    else $error("halted mark dropped");

  // A rejected instruction writes nothing and reports a zero value.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && bad_register) |-> (result_value == '0 && !halted))
    else $error("bad register result carries a value");

endmodule

### rtl/tieu_queue.sv
// ----------------------------------------------------------------------------
// tieu_queue
// Small synchronous FIFO used between the front and back and on the results.
// ----------------------------------------------------------------------------
module tieu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/tieu_front.sv
// ----------------------------------------------------------------------------
// tieu_front
// Accepts instructions, checks register numbers and picks the read ports.
// ----------------------------------------------------------------------------
module tieu_front #(
  parameter int NUM_REGS = 13
) (
  input  logic                                push,
  output logic                                full,
  input  logic                                busy,
  input  logic                                dq_full,
  input  logic [3:0]                          operation,
  input  logic [tieu_pkg::REG_NUM_W-1:0]      dest_reg,
  input  logic [tieu_pkg::REG_NUM_W-1:0]      src_reg,
  input  logic                                op2_is_imm,
  input  logic [tieu_pkg::REG_NUM_W-1:0]      op2_reg,
  input  logic [tieu_pkg::IMM_W-1:0]          op2_imm,
  input  logic [tieu_pkg::ADDR_IN_W-1:0]      mem_addr,
  output logic                                dq_push,
  output tieu_pkg::dec_item_t                 dq_item
);

  localparam int NW = tieu_pkg::REG_NUM_W + 1;

  logic uses_rd;
  logic uses_rs;
  logic uses_op2;
  logic rd_ok;
  logic rs_ok;
  logic r2_ok;
  logic port_a_rd;

  assign rd_ok = {1'b0, dest_reg} < NW'(NUM_REGS);
  assign rs_ok = {1'b0, src_reg}  < NW'(NUM_REGS);
  assign r2_ok = {1'b0, op2_reg}  < NW'(NUM_REGS);

  always_comb begin
    uses_rd   = 1'b1;
    uses_rs   = 1'b0;
    uses_op2  = 1'b0;
    port_a_rd = 1'b0;
    unique case (operation) inside
      tieu_pkg::OP_LDR: begin
      end
      tieu_pkg::OP_STR: begin
        port_a_rd = 1'b1;
      end
      tieu_pkg::OP_ADD, tieu_pkg::OP_SUB, tieu_pkg::OP_AND, tieu_pkg::OP_ORR,
      tieu_pkg::OP_EOR, tieu_pkg::OP_LSL, tieu_pkg::OP_LSR: begin
        uses_rs  = 1'b1;
        uses_op2 = 1'b1;
      end
      tieu_pkg::OP_MOV, tieu_pkg::OP_MVN: begin
        uses_op2 = 1'b1;
      end
      tieu_pkg::OP_CMP: begin
        uses_op2  = 1'b1;
        port_a_rd = 1'b1;
      end
      tieu_pkg::OP_HALT: begin
        uses_rd = 1'b0;
      end
      default: begin
        // unused codes execute as no-ops in the back
        uses_rd = 1'b0;
      end
    endcase
  end

  assign full    = busy || dq_full;
  assign dq_push = push && !full;

  always_comb begin
    dq_item.op      = operation;
    dq_item.bad     = (uses_rd && !rd_ok) || (uses_rs && !rs_ok) ||
                      (uses_op2 && !op2_is_imm && !r2_ok);
    dq_item.rd      = dest_reg;
    dq_item.ra      = port_a_rd ? dest_reg : src_reg;
    dq_item.rb      = op2_reg;
    dq_item.use_imm = op2_is_imm;
    dq_item.imm     = op2_imm;
    dq_item.addr    = mem_addr;
  end

endmodule

### rtl/tieu_back.sv
// ----------------------------------------------------------------------------
// tieu_back
// Two-stage execute: register file and data memory read, then ALU and write.
// ----------------------------------------------------------------------------
module tieu_back #(
  parameter int NUM_REGS   = 13,
  parameter int MEM_WORDS  = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  output logic                busy,
  input  logic                dq_empty,
  input  tieu_pkg::dec_item_t dq_item,
  output logic                dq_pop,
  input  logic                oq_full,
  output logic                oq_push,
  output tieu_pkg::result_t   oq_data
);

  localparam int RW = $clog2(NUM_REGS);
  localparam int AW = $clog2(MEM_WORDS);
  localparam int SW = $clog2(DATA_WIDTH);

  // Fold an 8-bit address into the memory range with four compare-subtract steps.
  function automatic logic [AW-1:0] fold_addr(input logic [tieu_pkg::ADDR_IN_W-1:0] a);
    logic [tieu_pkg::ADDR_IN_W-1:0] v;
    v = a;
    for (int k = 3; k >= 0; k--) begin
      if (32'(v) >= (MEM_WORDS << k)) begin
        v = v - tieu_pkg::ADDR_IN_W'(MEM_WORDS << k);
      end
    end
    return AW'(v);
  endfunction

  logic [DATA_WIDTH-1:0] rf  [NUM_REGS];
  logic [DATA_WIDTH-1:0] mem [MEM_WORDS];

  logic                  clearing;
  logic [AW-1:0]         clr_idx;

  logic                  s2_valid;
  tieu_pkg::dec_item_t   s2_item;
  logic [AW-1:0]         s2_addr;
  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;
  logic [DATA_WIDTH-1:0] mem_q;
  logic [1:0]            compare_flag;
  logic                  halt_mark;

  logic                  advance;
  logic [AW-1:0]         s1_addr;
  logic                  exec_on;
  logic                  live_op;
  logic [DATA_WIDTH-1:0] opb;
  logic [DATA_WIDTH-1:0] value;
  logic                  wr_reg_op;
  logic                  wr_mem_op;
  logic                  wr_reg;
  logic                  wr_mem;
  logic [1:0]            compare_flag_next;
  logic                  halt_mark_next;

  assign busy    = clearing;
  assign advance = !clearing && (!s2_valid || !oq_full);
  assign dq_pop  = advance && !dq_empty;
  assign s1_addr = fold_addr(dq_item.addr);

  // ---------------- execute stage
  assign live_op = !halt_mark && (s2_item.op <= tieu_pkg::OP_HALT);
  assign exec_on = live_op && !s2_item.bad;
  assign opb     = s2_item.use_imm ? DATA_WIDTH'(s2_item.imm) : rd_b;

  always_comb begin
    value             = '0;
    wr_reg_op         = 1'b0;
    wr_mem_op         = 1'b0;
    compare_flag_next = compare_flag;
    halt_mark_next    = halt_mark;
    if (exec_on) begin
      unique case (s2_item.op)
        tieu_pkg::OP_LDR: begin
          value     = mem_q;
          wr_reg_op = 1'b1;
        end
        tieu_pkg::OP_STR: begin
          value     = rd_a;
          wr_mem_op = 1'b1;
        end
        tieu_pkg::OP_ADD: begin
          value     = rd_a + opb;
          wr_reg_op = 1'b1;
        end
        tieu_pkg::OP_SUB: begin
          value     = rd_a - opb;
          wr_reg_op = 1'b1;
        end
        tieu_pkg::OP_MOV: begin
          value     = opb;
          wr_reg_op = 1'b1;
        end
        tieu_pkg::OP_CMP: begin
          if (rd_a == opb) begin
            compare_flag_next = tieu_pkg::CMP_EQ;
          end else if (rd_a > opb) begin
            compare_flag_next = tieu_pkg::CMP_GT;
          end else begin
            compare_flag_next = tieu_pkg::CMP_LT;
          end
        end
        tieu_pkg::OP_AND: begin
          value     = rd_a & opb;
          wr_reg_op = 1'b1;
        end
        tieu_pkg::OP_ORR: begin
          value     = rd_a | opb;
          wr_reg_op = 1'b1;
        end
        tieu_pkg::OP_EOR: begin
          value     = rd_a ^ opb;
          wr_reg_op = 1'b1;
        end
        tieu_pkg::OP_MVN: begin
          value     = ~opb;
          wr_reg_op = 1'b1;
        end
        tieu_pkg::OP_LSL: begin
          value     = (opb >= DATA_WIDTH'(DATA_WIDTH)) ? '0 : (rd_a << opb[SW-1:0]);
          wr_reg_op = 1'b1;
        end
        tieu_pkg::OP_LSR: begin
          value     = (opb >= DATA_WIDTH'(DATA_WIDTH)) ? '0 : (rd_a >> opb[SW-1:0]);
          wr_reg_op = 1'b1;
        end
        tieu_pkg::OP_HALT: begin
          halt_mark_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_reg  = s2_valid && advance && wr_reg_op;
  assign wr_mem  = s2_valid && advance && wr_mem_op;
  assign oq_push = s2_valid && advance;

  always_comb begin
    oq_data.value  = tieu_pkg::RESULT_W'(value);
    oq_data.cmp    = compare_flag_next;
    oq_data.halted = halt_mark_next;
    oq_data.bad    = live_op && s2_item.bad;
  end

  // ---------------- storage; the clearing pass shares the write ports
  always_ff @(posedge clk) begin
    if (clearing) begin
      if ({1'b0, clr_idx} < (AW + 1)'(NUM_REGS)) begin
        rf[clr_idx[RW-1:0]] <= '0;
      end
    end else if (wr_reg) begin
      rf[s2_item.rd[RW-1:0]] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (wr_mem) begin
      mem[s2_addr] <= rd_a;
    end
  end

  // Issue stage: registered reads, bypassing the write that retires this cycle.
  always_ff @(posedge clk) begin
    if (dq_pop) begin
      s2_item <= dq_item;
      s2_addr <= s1_addr;
      rd_a    <= (wr_reg && s2_item.rd == dq_item.ra) ? value : rf[dq_item.ra[RW-1:0]];
      rd_b    <= (wr_reg && s2_item.rd == dq_item.rb) ? value : rf[dq_item.rb[RW-1:0]];
      mem_q   <= (wr_mem && s2_addr == s1_addr) ? rd_a : mem[s1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_idx      <= '0;
      s2_valid     <= 1'b0;
      compare_flag <= tieu_pkg::CMP_EQ;
      halt_mark    <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == AW'(MEM_WORDS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (advance) begin
        s2_valid <= dq_pop;
      end
      if (s2_valid && advance) begin
        compare_flag <= compare_flag_next;
        halt_mark    <= halt_mark_next;
      end
    end
  end

endmodule
